[rtl/cmt_pkg.sv]
`timescale 1ns / 1ps
// cmt_pkg: shared types and constants for the compare-match timer channel.
// No dependencies; used by the interfaces, core, output buffer and checker.
package cmt_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// register map
	localparam logic [3:0] REG_CTRL    = 4'd0;
	localparam logic [3:0] REG_MODE    = 4'd1;
	localparam logic [3:0] REG_IO      = 4'd2;
	localparam logic [3:0] REG_INT_EN  = 4'd3;
	localparam logic [3:0] REG_STATUS  = 4'd4;
	localparam logic [3:0] REG_COUNTER = 4'd5;
	localparam logic [3:0] REG_CMP_A   = 4'd6;
	localparam logic [3:0] REG_CMP_B   = 4'd7;
	localparam logic [3:0] REG_CAPTURE = 4'd8;

	// control register fields
	localparam logic [2:0] CCLR_A     = 3'd1;
	localparam logic [2:0] CCLR_B     = 3'd2;
	localparam logic [2:0] PSC_DIV4   = 3'd1;
	localparam logic [2:0] PSC_DIV16  = 3'd2;
	localparam logic [2:0] PSC_DIV64  = 3'd3;

	localparam logic [7:0]  STATUS_RESET = 8'hC0;
	localparam logic [15:0] CMP_RESET    = 16'hFFFF;
	localparam int unsigned IEN_A_BIT    = 0;
	localparam int unsigned IEN_B_BIT    = 1;

	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  reg_index;
		logic [15:0] write_data;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq_a;
		logic        irq_b;
	} rsp_t;

	// prescaler divisor, one above the largest prescale count
	function automatic logic [6:0] psc_divisor(input logic [2:0] sel);
		case (sel)
			PSC_DIV4:  psc_divisor = 7'd4;
			PSC_DIV16: psc_divisor = 7'd16;
			PSC_DIV64: psc_divisor = 7'd64;
			default:   psc_divisor = 7'd1;
		endcase
	endfunction

endpackage

[rtl/cmt_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on cmt_pkg for the payload types.
interface cmt_req_if import cmt_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface cmt_rsp_if import cmt_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/cmt_core.sv]
`timescale 1ns / 1ps
// cmt_core: register bank, prescaler, counter and compare-match logic.
// Depends on cmt_pkg. State updates on accepted writes and ticks.
module cmt_core import cmt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  req_t req,
	output rsp_t result
);

	logic [7:0]  ctrl_q, mode_q, io_q, int_en_q, status_q, capture_q;
	logic [15:0] counter_q, cmp_a_q, cmp_b_q;
	logic [5:0]  psc_q;

	logic [6:0]  psc_next;
	logic        psc_wrap;
	logic [15:0] cnt1, cnt2, cnt3;
	logic        match_a, match_b, fire_a, fire_b;
	logic [15:0] rdata;

	// tick path: prescale, count, then compare A before compare B
	always_comb begin
		psc_next = {1'b0, psc_q} + 7'd1;
		psc_wrap = psc_next >= psc_divisor(ctrl_q[2:0]);
		cnt1     = psc_wrap ? counter_q + 16'd1 : counter_q;
		match_a  = cnt1 >= cmp_a_q;
		cnt2     = (match_a && ctrl_q[7:5] == CCLR_A) ? cnt1 - cmp_a_q : cnt1;
		match_b  = cnt2 >= cmp_b_q;
		cnt3     = (match_b && ctrl_q[7:5] == CCLR_B) ? cnt2 - cmp_b_q : cnt2;
		fire_a   = match_a && int_en_q[IEN_A_BIT];
		fire_b   = match_b && int_en_q[IEN_B_BIT];
	end

	always_comb begin
		case (req.reg_index)
			REG_CTRL:    rdata = {8'd0, ctrl_q};
			REG_MODE:    rdata = {8'd0, mode_q};
			REG_IO:      rdata = {8'd0, io_q};
			REG_INT_EN:  rdata = {8'd0, int_en_q};
			REG_STATUS:  rdata = {8'd0, status_q};
			REG_COUNTER: rdata = counter_q;
			REG_CMP_A:   rdata = cmp_a_q;
			REG_CMP_B:   rdata = cmp_b_q;
			REG_CAPTURE: rdata = {8'd0, capture_q};
			default:     rdata = 16'd0;
		endcase
	end

	always_comb begin
		result.read_data = (req.cmd == CMD_READ) ? rdata : 16'd0;
		result.irq_a     = (req.cmd == CMD_TICK) && fire_a;
		result.irq_b     = (req.cmd == CMD_TICK) && fire_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= 8'd0;
			mode_q    <= 8'd0;
			io_q      <= 8'd0;
			int_en_q  <= 8'd0;
			status_q  <= STATUS_RESET;
			capture_q <= 8'd0;
			counter_q <= 16'd0;
			cmp_a_q   <= CMP_RESET;
			cmp_b_q   <= CMP_RESET;
			psc_q     <= 6'd0;
		end else if (accept) begin
			case (req.cmd)
				CMD_WRITE: begin
					case (req.reg_index)
						REG_CTRL:    ctrl_q    <= req.write_data[7:0];
						REG_MODE:    mode_q    <= req.write_data[7:0];
						REG_IO:      io_q      <= req.write_data[7:0];
						REG_INT_EN:  int_en_q  <= req.write_data[7:0];
						REG_STATUS:  status_q  <= req.write_data[7:0];
						REG_COUNTER: counter_q <= req.write_data;
						REG_CMP_A:   cmp_a_q   <= req.write_data;
						REG_CMP_B:   cmp_b_q   <= req.write_data;
						REG_CAPTURE: capture_q <= req.write_data[7:0];
						default:     ;
					endcase
				end
				CMD_TICK: begin
					psc_q     <= psc_wrap ? 6'd0 : psc_next[5:0];
					counter_q <= cnt3;
					status_q  <= status_q | {6'd0, fire_b, fire_a};
				end
				default: ;
			endcase
		end
	end

endmodule

[rtl/cmt_obuf.sv]
`timescale 1ns / 1ps
// cmt_obuf: output register plus one skid entry for the response channel.
// Depends on cmt_pkg for rsp_t.
module cmt_obuf import cmt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  rsp_t in_data,
	output logic in_ready,
	output logic out_valid,
	output rsp_t out_data,
	input  logic out_ready
);

	logic out_valid_q, skid_valid_q;
	rsp_t out_q, skid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_valid) begin
				out_q <= in_data;
			end
		end else if (in_valid) begin
			skid_q <= in_data;
		end
	end

endmodule

[rtl/compare_match_timer_channel_top.sv]
`timescale 1ns / 1ps
// Compare-match timer channel, top level.
// Depends on cmt_pkg, cmt_if, cmt_core and cmt_obuf.
//
// Usage:
//  - req carries one transaction per handshake: a register read, a register
//    write, or one peripheral clock tick (cmd field). Command 3 is a no-op.
//  - rsp returns exactly one transaction per request, in order: read data
//    for reads (zero otherwise) and irq_a / irq_b flags for ticks
//    that hit an enabled compare match.
//  - Throughput: one request per cycle while req.ready is high.
//    The response is registered: the whole tick path (prescaler, counter
//    increment, compare A then B with optional counter clear) sits between
//    the state registers and the response register or skid entry.
//  - Register state updates at the accepting edge, so a following request
//    in the next cycle sees the effect of this one.
//  - Stall: a response register and a skid entry decouple the sides; one
//    more request is taken while a response waits, then req.ready drops
//    until the receiver takes a response.
//  - Reset (arst_n low, asynchronous): registers return to their defaults
//    (status 0xC0, compares 0xFFFF, all else zero) and no response is held.
module compare_match_timer_channel_top import cmt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	cmt_req_if.sink  req,
	cmt_rsp_if.source rsp
);

	logic accept;
	logic buf_ready;
	rsp_t core_result;

	assign req.ready = buf_ready;
	assign accept    = req.valid && buf_ready;

	// register bank and timer datapath
	cmt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.req    (req.data),
		.result (core_result)
	);

	// response register with skid entry
	cmt_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_data   (core_result),
		.in_ready  (buf_ready),
		.out_valid (rsp.valid),
		.out_data  (rsp.data),
		.out_ready (rsp.ready)
	);

endmodule

[rtl/cmt_checker.sv]
`timescale 1ns / 1ps
// cmt_checker: port-level assertions for the timer channel top level.
// Depends on cmt_pkg and cmt_if; bound to compare_match_timer_channel_top.
module cmt_checker import cmt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cmt_req_if.sink   req,
	cmt_rsp_if.source rsp
);

	// a taken request with an empty output shows a response next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && !rsp.valid) |=> rsp.valid)
		else $error("response missing one cycle after request");

	// back-pressure on req only when a response is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp.valid)
		else $error("request stalled with no response pending");

	// a response is either read data or interrupt flags, never both
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.data.read_data != 16'd0) |->
		(!rsp.data.irq_a && !rsp.data.irq_b))
		else $error("read data and irq in one transaction");

	// stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.data)))
		else $error("stalled response changed");

endmodule

bind compare_match_timer_channel_top cmt_checker u_cmt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);

[bench/tb_compare_match_timer_channel_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for compare_match_timer_channel_top: reset values, register
// access, prescaler, compare match and output back-pressure, then random traffic
// under random stalls. Depends on cmt_pkg, cmt_if and the RTL of the timer channel.
module tb_compare_match_timer_channel_top;
	import cmt_pkg::*;

	localparam int unsigned LIMIT_CYCLES  = 400000;
	localparam int unsigned DRAIN_CYCLES  = 16;
	localparam int unsigned RANDOM_ITEMS  = 1700;
	localparam int unsigned REPORT_LIMIT  = 10;

	logic clk;
	logic arst_n;

	cmt_req_if req_ch ();
	cmt_rsp_if rsp_ch ();

	compare_match_timer_channel_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the channel registers, advanced once per accepted request.
	logic [7:0]  tm_ctrl    = '0;
	logic [7:0]  tm_mode    = '0;
	logic [7:0]  tm_io      = '0;
	logic [7:0]  tm_ien     = '0;
	logic [7:0]  tm_status  = STATUS_RESET;
	logic [15:0] tm_count   = '0;
	logic [15:0] tm_cmp_a   = CMP_RESET;
	logic [15:0] tm_cmp_b   = CMP_RESET;
	logic [7:0]  tm_capture = '0;
	logic [5:0]  tm_psc     = '0;

	rsp_t        due_responses[$];	// responses owed by the block, oldest first
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          gaps_on        = 1'b1;	// both sides idle at random when set
	int unsigned sink_hold      = 0;	// long receiver hold-off, picked up by the sink

	// Clock and the single reset at the start of the run.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog: a hung handshake or a lost response ends here.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic int unsigned draw_gap();
		return gaps_on ? $urandom_range(0, 7) : 0;
	endfunction

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// One request through the shadow registers; returns the response it owes.
	function automatic rsp_t predict_timer_step(input req_t r);
		rsp_t       o;
		logic [6:0] div;
		logic [6:0] nxt;
		o = '0;
		case (r.cmd)
			CMD_READ: begin
				case (r.reg_index)
					REG_CTRL:    o.read_data = {8'h00, tm_ctrl};
					REG_MODE:    o.read_data = {8'h00, tm_mode};
					REG_IO:      o.read_data = {8'h00, tm_io};
					REG_INT_EN:  o.read_data = {8'h00, tm_ien};
					REG_STATUS:  o.read_data = {8'h00, tm_status};
					REG_COUNTER: o.read_data = tm_count;
					REG_CMP_A:   o.read_data = tm_cmp_a;
					REG_CMP_B:   o.read_data = tm_cmp_b;
					REG_CAPTURE: o.read_data = {8'h00, tm_capture};
					default:     o.read_data = '0;
				endcase
			end
			CMD_WRITE: begin
				// byte-wide registers keep the low byte only
				case (r.reg_index)
					REG_CTRL:    tm_ctrl    = r.write_data[7:0];
					REG_MODE:    tm_mode    = r.write_data[7:0];
					REG_IO:      tm_io      = r.write_data[7:0];
					REG_INT_EN:  tm_ien     = r.write_data[7:0];
					REG_STATUS:  tm_status  = r.write_data[7:0];
					REG_COUNTER: tm_count   = r.write_data;
					REG_CMP_A:   tm_cmp_a   = r.write_data;
					REG_CMP_B:   tm_cmp_b   = r.write_data;
					REG_CAPTURE: tm_capture = r.write_data[7:0];
					default: ;
				endcase
			end
			CMD_TICK: begin
				case (tm_ctrl[2:0])
					PSC_DIV4:  div = 7'd4;
					PSC_DIV16: div = 7'd16;
					PSC_DIV64: div = 7'd64;
					default:   div = 7'd1;
				endcase
				// a divisor lowered under the running count wraps on the next tick
				nxt = {1'b0, tm_psc} + 7'd1;
				if (nxt >= div) begin
					tm_psc   = '0;
					tm_count = tm_count + 16'd1;
				end else begin
					tm_psc = nxt[5:0];
				end
				// status flags share bit positions with the enables; A before B
				if (tm_count >= tm_cmp_a) begin
					if (tm_ien[IEN_A_BIT]) begin
						o.irq_a              = 1'b1;
						tm_status[IEN_A_BIT] = 1'b1;
					end
					if (tm_ctrl[7:5] == CCLR_A)
						tm_count = tm_count - tm_cmp_a;
				end
				if (tm_count >= tm_cmp_b) begin
					if (tm_ien[IEN_B_BIT]) begin
						o.irq_b              = 1'b1;
						tm_status[IEN_B_BIT] = 1'b1;
					end
					if (tm_ctrl[7:5] == CCLR_B)
						tm_count = tm_count - tm_cmp_b;
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// Request monitor: every accepted transaction is predicted at its accepting edge.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && req_ch.valid && req_ch.ready)
			due_responses.push_back(predict_timer_step(req_ch.data));
	end

	// Response checker: each accepted response against the oldest one owed.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && rsp_ch.valid && rsp_ch.ready) begin
			if (due_responses.size() == 0) begin
				report($sformatf("response with none owed: read_data %h irq_a %b irq_b %b",
					rsp_ch.data.read_data, rsp_ch.data.irq_a, rsp_ch.data.irq_b));
			end else begin
				want = due_responses.pop_front();
				if (rsp_ch.data.read_data !== want.read_data)
					report($sformatf("read_data: expected %h, got %h",
						want.read_data, rsp_ch.data.read_data));
				if (rsp_ch.data.irq_a !== want.irq_a)
					report($sformatf("irq_a: expected %b, got %b",
						want.irq_a, rsp_ch.data.irq_a));
				if (rsp_ch.data.irq_b !== want.irq_b)
					report($sformatf("irq_b: expected %b, got %b",
						want.irq_b, rsp_ch.data.irq_b));
			end
		end
	end

	// Receiver: random stalls per transaction, plus a long hold-off on request.
	initial begin : sink_side
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (sink_hold > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (sink_hold) @(posedge clk);
				sink_hold = 0;
			end
			stall = draw_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Sender: optional idle gap, then hold the transaction until it is taken.
	task automatic send_request(input cmd_t c, input logic [3:0] idx, input logic [15:0] wd);
		req_t        r;
		int unsigned gap;
		r.cmd        = c;
		r.reg_index  = idx;
		r.write_data = wd;
		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.data  <= r;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Reset defaults, an index off the map and the no-op command.
	task automatic test_reset_values();
		send_request(CMD_READ, REG_STATUS, 16'h0000);
		send_request(CMD_READ, REG_CMP_A, 16'h0000);
		send_request(CMD_READ, REG_CMP_B, 16'h0000);
		send_request(CMD_READ, 4'hF, 16'h0000);
		send_request(CMD_NOP, 4'hF, 16'hFFFF);
	endtask

	// Byte-wide truncation, whole-register status write, ignored write, counter extreme.
	task automatic test_register_access();
		send_request(CMD_WRITE, REG_MODE, 16'hFFFF);
		send_request(CMD_READ, REG_MODE, 16'h0000);
		send_request(CMD_WRITE, REG_STATUS, 16'h0000);
		send_request(CMD_READ, REG_STATUS, 16'h0000);
		send_request(CMD_WRITE, 4'd9, 16'hFFFF);
		send_request(CMD_WRITE, REG_COUNTER, 16'hFFFF);
		send_request(CMD_READ, REG_COUNTER, 16'h0000);
	endtask

	// Prescaler part-way through /16, then lowered to /4: next tick wraps and the
	// counter rolls over from all ones.
	task automatic test_prescaler();
		send_request(CMD_WRITE, REG_CTRL, {13'd0, PSC_DIV16});
		repeat (5) send_request(CMD_TICK, 4'd0, 16'h0000);
		send_request(CMD_WRITE, REG_CTRL, {13'd0, PSC_DIV4});
		send_request(CMD_TICK, 4'd0, 16'h0000);
		send_request(CMD_READ, REG_COUNTER, 16'h0000);
	endtask

	// Compare of zero with clear-on-A leaves the counter alone; then clear-on-B.
	task automatic test_compare_match();
		send_request(CMD_WRITE, REG_INT_EN, 16'h0003);
		send_request(CMD_WRITE, REG_CMP_A, 16'h0000);
		send_request(CMD_WRITE, REG_CTRL, {8'd0, CCLR_A, 5'd0});
		send_request(CMD_TICK, 4'd0, 16'h0000);
		send_request(CMD_WRITE, REG_CMP_B, 16'h0002);
		send_request(CMD_WRITE, REG_CTRL, {8'd0, CCLR_B, 5'd0});
		repeat (2) send_request(CMD_TICK, 4'd0, 16'h0000);
		send_request(CMD_READ, REG_STATUS, 16'h0000);
	endtask

	// Receiver holds off for a long stretch while requests keep coming back to back,
	// so the response path fills and req.ready must drop.
	task automatic test_output_backpressure();
		gaps_on   = 1'b0;
		sink_hold = 250;
		repeat (16) begin
			if ($urandom_range(0, 1))
				send_request(CMD_TICK, 4'd0, 16'h0000);
			else
				send_request(CMD_READ, 4'($urandom_range(0, 15)), 16'h0000);
		end
		gaps_on = 1'b1;
	endtask

	// Mostly ticks and writes of small compare/counter values so matches and clears
	// happen often; full-range data and every index now and then.
	task automatic test_random_traffic(input int unsigned n);
		int unsigned pick;
		logic [3:0]  idx;
		logic [15:0] wd;
		for (int unsigned i = 0; i < n; i++) begin
			if (i % 150 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			idx  = 4'($urandom_range(0, 15));
			wd   = 16'($urandom_range(0, 65535));
			if (pick < 50) begin
				send_request(CMD_TICK, idx, wd);
			end else if (pick < 72) begin
				if ($urandom_range(0, 2) != 0)
					idx = 4'($urandom_range(REG_CTRL, REG_CMP_B));
				if ((idx == REG_COUNTER || idx == REG_CMP_A || idx == REG_CMP_B)
						&& $urandom_range(0, 3) != 0)
					wd = 16'($urandom_range(0, 48));
				if (idx == REG_CTRL) begin
					// mostly clear-on-A/B or none, mostly no prescaling
					if ($urandom_range(0, 3) != 0)
						wd[7:5] = 3'($urandom_range(0, 2));
					if ($urandom_range(0, 3) != 0)
						wd[2:0] = 3'($urandom_range(0, 1));
				end
				send_request(CMD_WRITE, idx, wd);
			end else if (pick < 95) begin
				send_request(CMD_READ, idx, wd);
			end else begin
				send_request(CMD_NOP, idx, wd);
			end
		end
	endtask

	initial begin : stimulus
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		@(posedge arst_n);
		@(posedge clk);

		test_reset_values();
		test_register_access();
		test_prescaler();
		test_compare_match();
		test_output_backpressure();
		test_random_traffic(RANDOM_ITEMS);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && due_responses.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
